FILE: sv/cids_pkg.sv
// Shared constants, types and helpers for the frame statistics table.
package cids_pkg;

   // Table size and field widths.
   localparam int TABLE_ENTRIES = 64;
   localparam int ROW_W         = $clog2(TABLE_ENTRIES);
   localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);
   localparam int BUS_W         = 4;
   localparam int ID_W          = 29;
   localparam int KEY_W         = BUS_W + ID_W;
   localparam int TS_W          = 48;
   localparam int CNT_W         = 32;
   localparam int ROW_OUT_W     = 6;

   // Command codes.
   localparam logic CMD_RECORD = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   typedef logic [KEY_W-1:0] key_type;
   typedef logic [ROW_W-1:0] row_type;
   typedef logic [TS_W-1:0]  ts_type;

   // One accepted input transaction, with the lookup key already packed.
   typedef struct packed {
      logic   command;
      key_type key;
      ts_type timestamp;
   } item_type;

   // Outcome of the key search for one item.
   typedef struct packed {
      logic    hit;
      logic    is_new;
      logic    dropped;
      row_type row;
   } lookup_type;

   // Per-row statistics held in the entry memory.
   typedef struct packed {
      logic [CNT_W-1:0] count;
      ts_type           last_time;
      ts_type           period;
      logic             period_valid;
   } entry_type;

   // One result transaction.
   typedef struct packed {
      logic [ROW_OUT_W-1:0] row;
      logic                 is_new;
      logic                 dropped;
      logic [CNT_W-1:0]     frame_count;
      ts_type               period_us;
      logic                 period_valid;
   } result_type;

   // Row index as reported on the result channel.
   function automatic logic [ROW_OUT_W-1:0] row_field(input row_type row);
      return ROW_OUT_W'(row);
   endfunction

endpackage

FILE: sv/cids_if.sv
// Valid/ready channel interfaces for the frame and result transactions.
interface cids_req_if;
   import cids_pkg::*;

   logic              valid;
   logic              ready;
   logic              command;
   logic [BUS_W-1:0]  bus_number;
   logic [ID_W-1:0]   frame_id;
   logic [TS_W-1:0]   timestamp_us;

   modport source (output valid, command, bus_number, frame_id, timestamp_us,
                   input ready);
   modport sink   (input valid, command, bus_number, frame_id, timestamp_us,
                   output ready);
endinterface

interface cids_rsp_if;
   import cids_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ROW_OUT_W-1:0] row;
   logic                 is_new;
   logic                 dropped;
   logic [CNT_W-1:0]     frame_count;
   logic [TS_W-1:0]      period_us;
   logic                 period_valid;

   modport source (output valid, row, is_new, dropped, frame_count, period_us,
                   period_valid, input ready);
   modport sink   (input valid, row, is_new, dropped, frame_count, period_us,
                   period_valid, output ready);
endinterface

FILE: sv/can_id_frame_statistics_table.sv
// Top level of the frame statistics table: input register, two stages, result register.
//
// Each request transaction is either a received frame (bus number, identifier,
// microsecond timestamp) or a clear command. Frames are looked up by bus and
// identifier in a table of TABLE_ENTRIES rows. A known key has its count raised
// (saturating), its last timestamp replaced and its period updated when time
// did not go backwards; an unknown key takes the next free row; with the table
// full it is dropped and flagged. Every request yields exactly one response.
// An accepted request is loaded into the input register; the key compare outcome is then
// registered together with the entry memory read, and the update after that is loaded
// into the result register. One request is accepted per cycle while the result register
// is free or being emptied; the registered read of the entry memory is bypassed when
// back-to-back frames hit the same row.
// Synchronous reset empties the table at once: the fill count is cleared and
// rows are only read once written, so no clearing pass is needed.
// When the receiver stalls, the whole pipeline holds and req_chan.ready drops
// only while a finished response is waiting to be taken.
module can_id_frame_statistics_table (
   input  logic   clock,
   input  logic   reset,
   cids_req_if.sink   req_chan,
   cids_rsp_if.source rsp_chan
);
   import cids_pkg::*;

   logic                advance;
   logic                s1_valid_ff;
   item_type            s1_item_ff;
   lookup_type          s1_lookup;
   logic [USED_W-1:0]   used_count;
   logic                s2_valid;
   result_type          s2_result;
   logic                rsp_valid_ff;
   result_type          rsp_data_ff;

   // The pipeline moves whenever the result register is free or being emptied.
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_chan.valid) begin
         s1_item_ff.command   <= req_chan.command;
         s1_item_ff.key       <= {req_chan.bus_number, req_chan.frame_id};
         s1_item_ff.timestamp <= req_chan.timestamp_us;
      end
   end

   cids_key_match u_key_match (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item_valid (s1_valid_ff),
      .item       (s1_item_ff),
      .lookup     (s1_lookup),
      .used_count (used_count)
   );

   cids_entry_update u_entry_update (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .s1_valid  (s1_valid_ff),
      .s1_item   (s1_item_ff),
      .s1_lookup (s1_lookup),
      .s2_valid  (s2_valid),
      .s2_result (s2_result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= s2_result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.row          = rsp_data_ff.row;
   assign rsp_chan.is_new       = rsp_data_ff.is_new;
   assign rsp_chan.dropped      = rsp_data_ff.dropped;
   assign rsp_chan.frame_count  = rsp_data_ff.frame_count;
   assign rsp_chan.period_us    = rsp_data_ff.period_us;
   assign rsp_chan.period_valid = rsp_data_ff.period_valid;

`ifndef SYNTHESIS
   // The fill count never passes the table size.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_count <= USED_W'(TABLE_ENTRIES))
      else $error("fill count exceeds table size");

   // A lookup is at most one of hit, insert and drop.
   a_lookup_class: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $onehot0({s1_lookup.hit, s1_lookup.is_new, s1_lookup.dropped}))
      else $error("lookup classified more than one way");

   // A dropped frame reports nothing but the flag.
   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.dropped |->
         !rsp_chan.is_new && rsp_chan.frame_count == '0 && !rsp_chan.period_valid)
      else $error("dropped response carries statistics");

   // A freshly inserted key starts with a count of one and no period.
   a_new_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.is_new |->
         rsp_chan.frame_count == CNT_W'(1) && !rsp_chan.period_valid
         && rsp_chan.period_us == '0)
      else $error("new entry has wrong initial statistics");
`endif

endmodule

FILE: sv/cids_key_match.sv
// Key registers, fill count and parallel key compare for the first stage.
module cids_key_match (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    item_valid,
   input  cids_pkg::item_type      item,
   output cids_pkg::lookup_type    lookup,
   output logic [cids_pkg::USED_W-1:0] used_count
);
   import cids_pkg::*;

   key_type                 key_ff [TABLE_ENTRIES];
   logic [USED_W-1:0]       used_ff;
   logic [USED_W-1:0]       used_in;
   logic [TABLE_ENTRIES-1:0] hit_vec;
   row_type                 hit_row;
   logic                    record;
   logic                    full;
   logic                    take;

   // Compare the key against every occupied row; keys are unique, so an OR encode works.
   always_comb begin
      hit_row = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit_vec[i] = (USED_W'(i) < used_ff) && (key_ff[i] == item.key);
         if (hit_vec[i]) begin
            hit_row = hit_row | ROW_W'(i);
         end
      end
   end

   // Classify a record item as a hit, an insert or a drop; a clear is none of them.
   always_comb begin
      record         = (item.command == CMD_RECORD);
      full           = (used_ff == USED_W'(TABLE_ENTRIES));
      lookup.hit     = record && (|hit_vec);
      lookup.is_new  = record && !(|hit_vec) && !full;
      lookup.dropped = record && !(|hit_vec) && full;
      lookup.row     = (|hit_vec) ? hit_row : used_ff[ROW_W-1:0];
   end

   assign take = advance && item_valid;

   // Fill count: cleared by the clear command, raised by each insert.
   always_comb begin
      used_in = used_ff;
      if (take) begin
         if (item.command == CMD_CLEAR) begin
            used_in = '0;
         end else if (lookup.is_new) begin
            used_in = used_ff + USED_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // A new key goes into the next free row.
   always_ff @(posedge clock) begin
      if (take && lookup.is_new) begin
         key_ff[used_ff[ROW_W-1:0]] <= item.key;
      end
   end

   assign used_count = used_ff;

endmodule

FILE: sv/cids_entry_update.sv
// Entry memory read, statistics update and write-back for the second stage.
module cids_entry_update (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   s1_valid,
   input  cids_pkg::item_type     s1_item,
   input  cids_pkg::lookup_type   s1_lookup,
   output logic                   s2_valid,
   output cids_pkg::result_type   s2_result
);
   import cids_pkg::*;

   entry_type  mem [TABLE_ENTRIES];
   entry_type  rd_ff;
   entry_type  wb_ff;
   logic       fwd_ff;
   logic       fwd_in;
   logic       s2_valid_ff;
   item_type   s2_item_ff;
   lookup_type s2_lookup_ff;
   entry_type  cur;
   entry_type  nxt;
   logic       wr_en;
   logic       went_back;

   // The row written this cycle is the one the next item reads: forward it.
   assign fwd_in = wr_en && (s1_lookup.row == s2_lookup_ff.row);

   // Pipeline registers of the second stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_item_ff   <= s1_item;
         s2_lookup_ff <= s1_lookup;
      end
   end

   // Entry memory: one registered read and one write per cycle while the pipeline advances.
   always_ff @(posedge clock) begin
      if (advance) begin
         rd_ff <= mem[s1_lookup.row];
      end
      if (wr_en) begin
         mem[s2_lookup_ff.row] <= nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wb_ff <= nxt;
      end
   end

   assign wr_en = advance && s2_valid_ff && (s2_lookup_ff.hit || s2_lookup_ff.is_new);

   // New statistics for the row.
   always_comb begin
      cur       = fwd_ff ? wb_ff : rd_ff;
      went_back = s2_item_ff.timestamp < cur.last_time;
      if (s2_lookup_ff.is_new) begin
         nxt.count        = CNT_W'(1);
         nxt.last_time    = s2_item_ff.timestamp;
         nxt.period       = '0;
         nxt.period_valid = 1'b0;
      end else begin
         nxt.count        = (cur.count == COUNT_MAX) ? cur.count : cur.count + CNT_W'(1);
         nxt.last_time    = s2_item_ff.timestamp;
         nxt.period       = went_back ? cur.period : s2_item_ff.timestamp - cur.last_time;
         nxt.period_valid = went_back ? cur.period_valid : 1'b1;
      end
   end

   // Result transaction: all zero for a clear, only the flag for a drop.
   always_comb begin
      s2_result = '0;
      if (s2_lookup_ff.dropped) begin
         s2_result.dropped = 1'b1;
      end else if (s2_lookup_ff.hit || s2_lookup_ff.is_new) begin
         s2_result.row          = row_field(s2_lookup_ff.row);
         s2_result.is_new       = s2_lookup_ff.is_new;
         s2_result.frame_count  = nxt.count;
         s2_result.period_us    = nxt.period;
         s2_result.period_valid = nxt.period_valid;
      end
   end

   assign s2_valid = s2_valid_ff;

endmodule

FILE: tb/can_id_frame_statistics_table_tb.sv
// Self-checking testbench for the CAN frame statistics table: directed cases, then random traffic.
`timescale 1ns / 1ps

module can_id_frame_statistics_table_tb;
   import cids_pkg::*;

   // Tracks the expected table contents and the results still owed by the block.
   class frame_table_tracker;
      key_type          row_key[TABLE_ENTRIES];
      logic [CNT_W-1:0] row_count[TABLE_ENTRIES];
      ts_type           row_last[TABLE_ENTRIES];
      ts_type           row_period[TABLE_ENTRIES];
      logic             row_period_ok[TABLE_ENTRIES];
      int               rows_used = 0;
      result_type       pending_results[$];
      int               mismatches = 0;

      // Applies one accepted transaction to the table and queues its result.
      function void record_frame(item_type it);
         result_type r;
         int         i;
         int         hit;
         r   = '0;
         hit = -1;
         if (it.command == CMD_CLEAR) begin
            rows_used = 0;
         end else begin
            for (i = 0; i < rows_used; i++) begin
               if (hit < 0 && row_key[i] == it.key) hit = i;
            end
            if (hit >= 0) begin
               // The period only moves forward when time did not run backwards.
               if (it.timestamp >= row_last[hit]) begin
                  row_period[hit]    = it.timestamp - row_last[hit];
                  row_period_ok[hit] = 1'b1;
               end
               row_last[hit] = it.timestamp;
               if (row_count[hit] != COUNT_MAX) row_count[hit] = row_count[hit] + 1'b1;
               r.row          = ROW_OUT_W'(hit);
               r.frame_count  = row_count[hit];
               r.period_us    = row_period[hit];
               r.period_valid = row_period_ok[hit];
            end else if (rows_used >= TABLE_ENTRIES) begin
               r.dropped = 1'b1;
            end else begin
               row_key[rows_used]       = it.key;
               row_count[rows_used]     = 1;
               row_last[rows_used]      = it.timestamp;
               row_period[rows_used]    = '0;
               row_period_ok[rows_used] = 1'b0;
               r.row         = ROW_OUT_W'(rows_used);
               r.is_new      = 1'b1;
               r.frame_count = 1;
               rows_used++;
            end
         end
         pending_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
         end
      endfunction

      // Matches one accepted result against the oldest expectation.
      function void check_result(result_type got);
         result_type want;
         if (pending_results.size() == 0) begin
            $error("result transaction with no expectation pending");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            compare_field("row", 64'(want.row), 64'(got.row));
            compare_field("is_new", 64'(want.is_new), 64'(got.is_new));
            compare_field("dropped", 64'(want.dropped), 64'(got.dropped));
            compare_field("frame_count", 64'(want.frame_count), 64'(got.frame_count));
            compare_field("period_us", 64'(want.period_us), 64'(got.period_us));
            compare_field("period_valid", 64'(want.period_valid), 64'(got.period_valid));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   cids_req_if req_chan ();
   cids_rsp_if rsp_chan ();

   can_id_frame_statistics_table dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   frame_table_tracker tracker = new;

   int     frames_sent  = 0;
   int     burst_left   = 0;
   bit     offering     = 1'b0;
   bit     hold_active  = 1'b0;
   bit     hold_done    = 1'b0;
   ts_type bus_clock_us = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic key_type make_key(logic [BUS_W-1:0] bus, logic [ID_W-1:0] id);
      return {bus, id};
   endfunction

   function automatic key_type random_key();
      logic [BUS_W-1:0] bus;
      logic [ID_W-1:0]  id;
      bus = BUS_W'($urandom_range(0, 15));
      // Mix standard 11-bit identifiers with extended 29-bit ones.
      if ($urandom_range(0, 1) == 0) id = ID_W'($urandom_range(0, 2047));
      else id = ID_W'($urandom);
      return make_key(bus, id);
   endfunction

   // Mostly a steadily advancing bus time, with occasional jumps that may run backwards.
   function automatic ts_type next_timestamp();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
         bus_clock_us = ts_type'({$urandom, $urandom});
      end else if (pick == 2) begin
         bus_clock_us = '1 - ts_type'($urandom_range(0, 1000));
      end else begin
         bus_clock_us = bus_clock_us + ts_type'($urandom_range(0, 5000));
      end
      return bus_clock_us;
   endfunction

   // Offers one transaction, waits for its acceptance, then paces the next one.
   task automatic send_frame(logic cmd, key_type key, ts_type ts);
      item_type it;
      int       gap;
      req_chan.valid        <= 1'b1;
      req_chan.command      <= cmd;
      req_chan.bus_number   <= key[KEY_W-1:ID_W];
      req_chan.frame_id     <= key[ID_W-1:0];
      req_chan.timestamp_us <= ts;
      offering = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      it.command   = cmd;
      it.key       = key;
      it.timestamp = ts;
      tracker.record_frame(it);
      frames_sent++;
      // Bursts of back-to-back transactions separated by random gaps.
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap        = $urandom_range(0, 6);
         if (!hold_active && gap > 0) begin
            req_chan.valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_record(key_type key, ts_type ts);
      send_frame(CMD_RECORD, key, ts);
   endtask

   task automatic send_clear();
      send_frame(CMD_CLEAR, random_key(), ts_type'({$urandom, $urandom}));
   endtask

   // Result side: checks accepted transactions and stalls on its own pattern.
   initial begin
      logic [7:0] stall_mask;
      int         phase;
      result_type got;
      stall_mask = '1;
      phase      = 0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.row          = rsp_chan.row;
            got.is_new       = rsp_chan.is_new;
            got.dropped      = rsp_chan.dropped;
            got.frame_count  = rsp_chan.frame_count;
            got.period_us    = rsp_chan.period_us;
            got.period_valid = rsp_chan.period_valid;
            tracker.check_result(got);
         end
         // One long hold-off so the pipeline fills and back-pressures the input.
         if (!hold_done && frames_sent >= 250) begin
            hold_active = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (60) @(posedge clock);
            hold_active = 1'b0;
            hold_done   = 1'b1;
         end
         if (phase % 64 == 0) begin
            if ($urandom_range(0, 3) == 0) stall_mask = '1;
            else stall_mask = 8'($urandom) | 8'h01;
         end
         rsp_chan.ready <= stall_mask[phase % 8];
         phase++;
      end
   end

   // Request side: reset, directed cases, random episodes, drain.
   initial begin
      key_type key_pool[$];
      key_type k_lo;
      key_type k_hi;
      int      random_sent;
      int      kind;
      int      pool_size;
      int      length;
      int      n;
      req_chan.valid        <= 1'b0;
      req_chan.command      <= CMD_RECORD;
      req_chan.bus_number   <= '0;
      req_chan.frame_id     <= '0;
      req_chan.timestamp_us <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: key and time extremes, backwards time, equal time, clears.
      k_lo = make_key('0, '0);
      k_hi = make_key('1, '1);
      send_frame(CMD_CLEAR, k_hi, '1);
      send_record(k_lo, '0);
      send_record(k_lo, '0);
      send_record(k_hi, '1);
      send_record(k_hi, 48'd5);
      send_record(k_hi, '1);
      send_record(k_hi, '0);
      send_record(k_lo, 48'd1000);
      send_record(make_key('0, '1), '0);
      send_record(make_key('1, '0), '0);
      send_record(make_key(4'd1, 29'h7FF), 48'h0000_FFFF_FFFF);
      send_record(make_key(4'd1, 29'h7FF), 48'hFFFF_0000_0000);
      send_frame(CMD_CLEAR, k_lo, '0);
      send_record(k_lo, 48'd50);
      send_record(k_lo, 48'd40);
      send_record(k_lo, 48'd40);
      send_record(k_hi, 48'd41);

      // Random episodes; the first one fills the table past capacity.
      random_sent = 0;
      kind        = 0;
      while (random_sent < 700) begin
         key_pool.delete();
         if (kind <= 1) begin
            // Fill: every pool key once, so the table fills and later keys drop.
            send_clear();
            pool_size = TABLE_ENTRIES + $urandom_range(1, 10);
            for (n = 0; n < pool_size; n++) key_pool.push_back(random_key());
            foreach (key_pool[j]) send_record(key_pool[j], next_timestamp());
            for (n = 0; n < 20; n++) begin
               send_record(key_pool[$urandom_range(0, pool_size - 1)], next_timestamp());
            end
            random_sent += pool_size + 21;
         end else if (kind <= 8) begin
            // Typical traffic: a few periodic identifiers, rare clears.
            if ($urandom_range(0, 2) == 0) send_clear();
            pool_size = $urandom_range(1, 12);
            for (n = 0; n < pool_size; n++) key_pool.push_back(random_key());
            length = $urandom_range(10, 40);
            for (n = 0; n < length; n++) begin
               if ($urandom_range(0, 19) == 0) send_clear();
               else send_record(key_pool[$urandom_range(0, pool_size - 1)], next_timestamp());
            end
            random_sent += length + 1;
         end else begin
            // Noise: unrelated keys, full-range times and random commands.
            for (n = 0; n < 10; n++) begin
               send_frame(($urandom_range(0, 7) == 0) ? CMD_CLEAR : CMD_RECORD,
                          random_key(), ts_type'({$urandom, $urandom}));
            end
            random_sent += 10;
         end
         kind = $urandom_range(0, 9);
      end

      if (offering) req_chan.valid <= 1'b0;
      while (tracker.pending_results.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
